/* rtl/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES byte stream package
// Shared types, constants and byte-level functions for the AES byte cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundIdxW = 4;
  localparam int unsigned AddrW     = 5;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_LEN  = 3'd4,
    REG_MODE = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_KEYEXP,
    ST_START,
    ST_ROUND,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic       load_byte;   // store input byte, advance counters
    logic       key_init;    // load key registers into expansion regs
    logic       key_step;    // expand one round key
    logic       blk_start;   // apply first key, latch mode
    logic       round_step;  // one cipher round
    logic       emit_shift;  // move one output byte on
  } dp_cmd_t;

  typedef struct packed {
    logic       len_zero;
    logic       job_start;   // no byte of the current job taken yet
    logic       block_close; // accepted byte closes the block
    logic       key_done;
    logic       round_done;
    logic       emit_done;
  } dp_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] isbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
      8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
      8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
      8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
      8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
      8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
      8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
      8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
      8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
      8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
      8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
      8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
      8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
      8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
      8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
      8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
      8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [RoundIdxW-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

/* rtl/aes_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/aes_datapath.sv */
// ----------------------------------------------------------------------------
// AES datapath
// Block gathering, key expansion, iterative round unit and output shifter.
// ----------------------------------------------------------------------------
module aes_datapath (
  input  logic                clk,
  input  logic                rst,
  input  aes_pkg::dp_cmd_t    cmd,
  output aes_pkg::dp_stat_t   stat,
  input  logic [7:0]          data_byte,
  input  logic [127:0]        key,
  input  logic [31:0]         data_length_bytes,
  input  logic                decrypt_mode,
  output logic [7:0]          out_byte,
  output logic                last_of_job
);

  logic [3:0]   byte_position;
  logic [31:0]  bytes_consumed;
  logic [127:0] blk;
  logic [127:0] blk_next;
  logic [127:0] kexp;
  logic [3:0]   kround;
  logic [3:0]   round;
  logic         dec;
  logic         job_last;
  logic [4:0]   emit_cnt;
  logic [127:0] st;
  logic [31:0]  consumed_inc;
  logic         is_last;
  logic [127:0] kexp_next;
  logic [127:0] round_next;
  logic [127:0] rk_rdata;
  logic [3:0]   rk_raddr;

  assign consumed_inc = bytes_consumed + 32'd1;
  assign is_last      = consumed_inc >= data_length_bytes;

  assign stat.len_zero    = (data_length_bytes == 32'd0);
  assign stat.job_start   = (bytes_consumed == 32'd0) && (byte_position == 4'd0);
  assign stat.block_close = is_last || (byte_position == 4'd15);
  assign stat.key_done    = (kround == 4'(aes_pkg::NumRounds));
  assign stat.round_done  = (round == 4'(aes_pkg::NumRounds));
  assign stat.emit_done   = (emit_cnt == 5'd15);

  // byte i of the block in bits [127-8i -: 8]
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      bytes_consumed <= '0;
    end else if (cmd.load_byte) begin
      if (stat.block_close) begin
        byte_position <= '0;
      end else begin
        byte_position <= byte_position + 4'd1;
      end
      bytes_consumed <= is_last ? 32'd0 : consumed_inc;
    end
  end

  // key expansion, one round key per cycle into the store
  always_comb begin
    logic [31:0] w0, w1, w2, w3, t;
    w0 = kexp[127:96];
    w1 = kexp[95:64];
    w2 = kexp[63:32];
    w3 = kexp[31:0];
    t  = {aes_pkg::sbox(w3[23:16]) ^ aes_pkg::rcon(kround + 4'd1),
          aes_pkg::sbox(w3[15:8]), aes_pkg::sbox(w3[7:0]), aes_pkg::sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    kexp_next = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (cmd.key_init) begin
      kexp   <= key;
      kround <= '0;
    end else if (cmd.key_step) begin
      kexp   <= kexp_next;
      kround <= kround + 4'd1;
    end
  end

  aes_ram #(.Width(128), .Depth(16)) u_rk (
    .clk   (clk),
    .we    (cmd.key_init || cmd.key_step),
    .waddr (cmd.key_init ? 4'd0 : kround + 4'd1),
    .wdata (cmd.key_init ? key : kexp_next),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  // read address is given in the cycle before the round that uses its key
  always_comb begin
    if (cmd.blk_start) begin
      rk_raddr = decrypt_mode ? 4'd9 : 4'd1;
    end else if (dec) begin
      rk_raddr = 4'(aes_pkg::NumRounds) - round - 4'd2;
    end else begin
      rk_raddr = round + 4'd2;
    end
    if (cmd.load_byte || cmd.key_step || cmd.key_init) begin
      rk_raddr = decrypt_mode ? 4'd10 : 4'd0;
    end
  end

  function automatic logic [7:0] xt_f(input logic [7:0] x);
    return aes_pkg::xt(x);
  endfunction

  function automatic logic [7:0] mul(input logic [7:0] x, input logic [3:0] c);
    logic [7:0] x2, x4, x8, r;
    x2 = xt_f(x);
    x4 = xt_f(x2);
    x8 = xt_f(x4);
    r = (c[0] ? x : 8'h00) ^ (c[1] ? x2 : 8'h00) ^ (c[2] ? x4 : 8'h00) ^ (c[3] ? x8 : 8'h00);
    return r;
  endfunction

  always_comb begin
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic       final_rnd;
    final_rnd = (round == 4'(aes_pkg::NumRounds) - 4'd1);
    for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
    if (!dec) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[4*c+r] = aes_pkg::sbox(s[4*((c+r)%4)+r]);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          m[4*c+r] = mul(t[4*c+r], 4'd2) ^ mul(t[4*c+(r+1)%4], 4'd3)
                   ^ t[4*c+(r+2)%4] ^ t[4*c+(r+3)%4];
      for (int i = 0; i < 16; i++) begin
        m[i] = (final_rnd ? t[i] : m[i]) ^ rk_rdata[127-8*i -: 8];
      end
    end else begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[4*c+r] = aes_pkg::isbox(s[4*((c+3*r)%4)+r]) ^ rk_rdata[127-8*(4*c+r) -: 8];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          m[4*c+r] = mul(t[4*c+r], 4'he) ^ mul(t[4*c+(r+1)%4], 4'hb)
                   ^ mul(t[4*c+(r+2)%4], 4'hd) ^ mul(t[4*c+(r+3)%4], 4'h9);
      for (int i = 0; i < 16; i++) begin
        m[i] = final_rnd ? t[i] : m[i];
      end
    end
    for (int i = 0; i < 16; i++) round_next[127-8*i -: 8] = m[i];
  end

  // incoming byte into its slot; the closing byte of a job zeroes the rest
  always_comb begin
    blk_next = blk;
    blk_next[127-8*byte_position -: 8] = data_byte;
    if (is_last) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) > byte_position) blk_next[127-8*i -: 8] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      blk      <= blk_next;
      job_last <= is_last;
    end
    if (cmd.blk_start) begin
      st    <= blk ^ rk_rdata;
      round <= '0;
      dec   <= decrypt_mode;
    end else if (cmd.round_step) begin
      st    <= round_next;
      round <= round + 4'd1;
    end else if (cmd.emit_shift) begin
      st <= {st[119:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_start) begin
      emit_cnt <= '0;
    end else if (cmd.emit_shift) begin
      emit_cnt <= emit_cnt + 5'd1;
    end
  end

  assign out_byte    = st[127:120];
  assign last_of_job = job_last && stat.emit_done;

endmodule

/* rtl/aes_ctrl.sv */
// ----------------------------------------------------------------------------
// AES controller
// Sequences byte gathering, key expansion, rounds and byte output.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  aes_pkg::dp_stat_t stat,
  output aes_pkg::dp_cmd_t  cmd
);

  aes_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      aes_pkg::ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid && !stat.len_zero) begin
          if (stat.job_start) begin
            cmd.key_init = 1'b1;
            state_next   = aes_pkg::ST_KEYEXP;
            in_ready     = 1'b0;
          end else begin
            cmd.load_byte = 1'b1;
            if (stat.block_close) state_next = aes_pkg::ST_START;
          end
        end
      end
      aes_pkg::ST_KEYEXP: begin
        if (stat.key_done) begin
          state_next = aes_pkg::ST_COLLECT;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.load_byte = 1'b1;
            if (stat.block_close) state_next = aes_pkg::ST_START;
          end
        end else begin
          cmd.key_step = 1'b1;
        end
      end
      aes_pkg::ST_START: begin
        cmd.blk_start = 1'b1;
        state_next    = aes_pkg::ST_ROUND;
      end
      aes_pkg::ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (stat.round_done) begin
          cmd.round_step = 1'b0;
          state_next     = aes_pkg::ST_EMIT;
        end
      end
      aes_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_shift = 1'b1;
          if (stat.emit_done) state_next = aes_pkg::ST_COLLECT;
        end
      end
      default: state_next = aes_pkg::ST_COLLECT;
    endcase
  end

endmodule

/* rtl/aes128_ecb_byte_stream_cipher_unit.sv */
// ----------------------------------------------------------------------------
// AES-128 ECB byte stream cipher
// Gathers bytes into 16-byte blocks and encrypts or decrypts each block.
// ----------------------------------------------------------------------------
// Input beats carry one byte in s_tdata. Bytes fill a 16-byte block; a block
// closes on its 16th byte or on the last byte of a job of data_length_bytes,
// zero padded. Each closed block gives 16 output beats, byte 0 first, with
// m_tlast on byte 15 of the final block of a job.
// On the first byte of a job the key is expanded before the byte is taken.
// A closed block takes a key add, 10 rounds and one hand-over step on a
// single iterative round unit before its first output beat; then come 16
// output beats, one per cycle while the receiver is ready. Input is not
// taken while a block is being processed or emitted.
// A stalled receiver holds the output beat; the round unit waits.
// Reset clears the byte counters and controller; key, length and mode registers
// return to zero. A byte sent while data_length_bytes is zero is dropped.
// Registers via APB: key words at 0x00-0x0c, length 0x10, mode 0x14.
// ----------------------------------------------------------------------------
module aes128_ecb_byte_stream_cipher_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // data_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // out_byte
  output logic                      m_tlast,   // last_of_job
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [aes_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [31:0] key_word [4];
  logic [31:0] data_length_bytes;
  logic        decrypt_mode;
  aes_pkg::dp_cmd_t  cmd;
  aes_pkg::dp_stat_t stat;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
      data_length_bytes <= '0;
      decrypt_mode      <= 1'b0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        aes_pkg::REG_KEY0: key_word[0]       <= pwdata;
        aes_pkg::REG_KEY1: key_word[1]       <= pwdata;
        aes_pkg::REG_KEY2: key_word[2]       <= pwdata;
        aes_pkg::REG_KEY3: key_word[3]       <= pwdata;
        aes_pkg::REG_LEN:  data_length_bytes <= pwdata;
        aes_pkg::REG_MODE: decrypt_mode      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      aes_pkg::REG_KEY0: prdata = key_word[0];
      aes_pkg::REG_KEY1: prdata = key_word[1];
      aes_pkg::REG_KEY2: prdata = key_word[2];
      aes_pkg::REG_KEY3: prdata = key_word[3];
      aes_pkg::REG_LEN:  prdata = data_length_bytes;
      aes_pkg::REG_MODE: prdata = {31'd0, decrypt_mode};
      default:           prdata = '0;
    endcase
  end

  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  aes_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .data_byte         (s_tdata),
    .key               ({key_word[0], key_word[1], key_word[2], key_word[3]}),
    .data_length_bytes (data_length_bytes),
    .decrypt_mode      (decrypt_mode),
    .out_byte          (m_tdata),
    .last_of_job       (m_tlast)
  );

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while block emitted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed under stall");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("beats after last");

endmodule
